FILE: hdl/pnl_pkg.sv
package pnl_pkg;

    localparam int MAX_TYPES      = 4;
    localparam int MAX_CENTERS    = 256;
    localparam int SLOTS_PER_PAGE = 8;
    localparam int MAX_PAGES      = 512;
    localparam int MAX_PER_CENTER = 64;
    localparam int PAIR_BITS      = 16;

    localparam int TYPE_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int ATOMS_W  = 9;
    localparam int BASE_W   = 11;
    localparam int CENTER_W = 8;
    localparam int SLOT_W   = 3;
    localparam int PAGE_W   = 9;
    localparam int PTR_W    = 10;
    localparam int CNT_W    = 7;
    localparam int TAKEN_W  = 10;
    localparam int ADDR_W   = PAGE_W + SLOT_W;

    localparam logic [PTR_W-1:0] NO_PAGE = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_WALK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_TYPE    = 3'd1,
        ST_BAD_INDEX   = 3'd2,
        ST_POOL_FULL   = 3'd3,
        ST_CENTER_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_WREAD,
        BK_WEMIT
    } bk_state_t;

    typedef struct packed {
        cmd_t                  cmd;
        status_t               status;
        logic [CENTER_W-1:0]   center;
        logic [PAIR_BITS-1:0]  pair;
    } req_t;

    typedef struct packed {
        logic [PTR_W-1:0] first;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } ctr_rec_t;

    typedef struct packed {
        logic [PAIR_BITS-1:0] pair;
        logic                 has_pair;
        logic [CNT_W-1:0]     entry_count;
        logic                 last;
        status_t              status;
    } result_t;

endpackage

FILE: hdl/paged_neighbor_list.sv
// Paged neighbor list.
// Input channel (in_valid/in_stall) carries one request: command, center_type,
// atom_index, pair_value. Output channel (out_valid/out_stall) carries
// results; each request gives one result, except a walk of a non-empty
// center, which gives one result per stored entry, in append order, with
// last set on the final one.
// Config: cfg_we writes cfg_data into type count register cfg_index; write
// only while no request is in flight.
// Timing: an accepted request is registered in the request queue before the
// back end sees it. Clear and errors are answered from idle; append and query
// first read the center record (lookup), then answer. A walk then reads slot
// and link (WREAD), then emits the entry (WEMIT), for each stored entry.
// A two-entry request queue sits between the classifier and the executor,
// so up to two requests are taken while the back end is busy.
// Reset clears all lists, the page pool and the type counts. A clear command
// does the same for lists and pool (per-center valid bits).
// When out_stall is high the result register holds and the back end waits at its next result.
module paged_neighbor_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [pnl_pkg::TYPE_W-1:0]    center_type,
    input  logic [pnl_pkg::INDEX_W-1:0]   atom_index,
    input  logic [pnl_pkg::PAIR_BITS-1:0] pair_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pnl_pkg::PAIR_BITS-1:0] pair_out,
    output logic                          has_pair,
    output logic [pnl_pkg::CNT_W-1:0]     entry_count,
    output logic                          last,
    output logic [2:0]                    status,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [pnl_pkg::ATOMS_W-1:0]   cfg_data
);
    import pnl_pkg::*;

    logic    req_valid, req_pop;
    req_t    req;
    result_t res;

    pnl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .center_type (center_type),
        .atom_index  (atom_index),
        .pair_value  (pair_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req         (req),
        .req_pop     (req_pop)
    );

    pnl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign pair_out    = res.pair;
    assign has_pair    = res.has_pair;
    assign entry_count = res.entry_count;
    assign last        = res.last;
    assign status      = res.status;

endmodule

FILE: hdl/pnl_front.sv
module pnl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [pnl_pkg::TYPE_W-1:0]    center_type,
    input  logic [pnl_pkg::INDEX_W-1:0]   atom_index,
    input  logic [pnl_pkg::PAIR_BITS-1:0] pair_value,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [pnl_pkg::ATOMS_W-1:0]   cfg_data,
    output logic                          req_valid,
    output pnl_pkg::req_t                 req,
    input  logic                          req_pop
);
    import pnl_pkg::*;

    logic [ATOMS_W-1:0] atoms_reg [MAX_TYPES];
    logic [BASE_W-1:0]  base;
    logic [BASE_W-1:0]  id_sum;
    req_t               cls;
    req_t               q_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic               push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TYPES; i++)
                atoms_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            atoms_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        case (center_type)
            2'd0:    base = '0;
            2'd1:    base = BASE_W'(atoms_reg[0]);
            2'd2:    base = BASE_W'(atoms_reg[0]) + BASE_W'(atoms_reg[1]);
            default: base = BASE_W'(atoms_reg[0]) + BASE_W'(atoms_reg[1])
                            + BASE_W'(atoms_reg[2]);
        endcase
        id_sum     = base + BASE_W'(atom_index);
        cls.cmd    = cmd_t'(command);
        cls.pair   = pair_value;
        cls.center = id_sum[CENTER_W-1:0];
        cls.status = ST_OK;
        if (cls.cmd != CMD_CLEAR)
        begin
            if (ATOMS_W'(atom_index) >= atoms_reg[center_type]
                || id_sum >= BASE_W'(MAX_CENTERS))
                cls.status = ST_BAD_INDEX;
        end
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (req_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, req_pop};
        end
    end

endmodule

FILE: hdl/pnl_back.sv
module pnl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  pnl_pkg::req_t   req,
    output logic            req_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output pnl_pkg::result_t res
);
    import pnl_pkg::*;

    ctr_rec_t             ctr_mem [MAX_CENTERS];
    logic [PAIR_BITS-1:0] slot_mem [MAX_PAGES*SLOTS_PER_PAGE];
    logic [PTR_W-1:0]     link_mem [MAX_PAGES];

    bk_state_t            state_reg, state_next;
    req_t                 cur_reg, cur_next;
    logic [MAX_CENTERS-1:0] vld_reg, vld_next;
    ctr_rec_t             ctr_rd_reg;
    logic                 ctr_vld_rd_reg;
    logic [PAIR_BITS-1:0] slot_rd_reg;
    logic [PTR_W-1:0]     link_rd_reg;
    logic [TAKEN_W-1:0]   taken_reg, taken_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [PAGE_W-1:0]    wpage_reg, wpage_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic                 ctr_re, ctr_we, slot_we, slot_re, link_we;
    ctr_rec_t             ctr_wdata, rec;
    logic [ADDR_W-1:0]    slot_waddr;
    logic [PAGE_W-1:0]    link_waddr, np;
    logic                 out_free, emit;
    result_t              emit_val;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk)
    begin
        if (ctr_re)
            ctr_rd_reg <= ctr_mem[req.center];
        if (ctr_we)
            ctr_mem[cur_reg.center] <= ctr_wdata;
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[{wpage_reg, slot_reg}];
            link_rd_reg <= link_mem[wpage_reg];
        end
        if (slot_we)
            slot_mem[slot_waddr] <= cur_reg.pair;
        if (link_we)
            link_mem[link_waddr] <= {1'b0, np};
        cur_reg   <= cur_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        wpage_reg <= wpage_next;
        slot_reg  <= slot_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            vld_reg        <= '0;
            ctr_vld_rd_reg <= 1'b0;
            taken_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
            if (ctr_re)
                ctr_vld_rd_reg <= vld_reg[req.center];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        vld_next   = vld_reg;
        taken_next = taken_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        wpage_next = wpage_reg;
        slot_next  = slot_reg;
        req_pop    = 1'b0;
        ctr_re     = 1'b0;
        ctr_we     = 1'b0;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        link_we    = 1'b0;
        ctr_wdata  = '0;
        slot_waddr = '0;
        link_waddr = '0;
        np         = taken_reg[PAGE_W-1:0];
        emit       = 1'b0;
        emit_val   = '{pair: '0, has_pair: 1'b0, entry_count: '0, last: 1'b1,
                       status: ST_OK};
        rec        = ctr_vld_rd_reg ? ctr_rd_reg
                                    : '{first: NO_PAGE, tail: NO_PAGE, count: '0};

        case (state_reg)
            BK_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.cmd == CMD_CLEAR || req.status != ST_OK)
                    begin
                        if (out_free)
                        begin
                            emit            = 1'b1;
                            emit_val.status = req.status;
                            req_pop         = 1'b1;
                            if (req.cmd == CMD_CLEAR)
                            begin
                                vld_next   = '0;
                                taken_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        req_pop    = 1'b1;
                        ctr_re     = 1'b1;
                        cur_next   = req;
                        state_next = BK_LOOKUP;
                    end
                end
            end
            BK_LOOKUP:
            begin
                if (cur_reg.cmd == CMD_WALK && rec.count != '0)
                begin
                    n_next     = rec.count;
                    idx_next   = '0;
                    wpage_next = rec.first[PAGE_W-1:0];
                    slot_next  = '0;
                    state_next = BK_WREAD;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                    if (cur_reg.cmd == CMD_APPEND)
                    begin
                        if (rec.count >= CNT_W'(MAX_PER_CENTER))
                            emit_val.status = ST_CENTER_FULL;
                        else if (rec.count[SLOT_W-1:0] == '0
                                 && taken_reg >= TAKEN_W'(MAX_PAGES))
                            emit_val.status = ST_POOL_FULL;
                        else
                        begin
                            emit_val.entry_count = rec.count + 1'b1;
                            ctr_we            = 1'b1;
                            ctr_wdata.count   = rec.count + 1'b1;
                            ctr_wdata.first   = rec.first;
                            ctr_wdata.tail    = rec.tail;
                            vld_next[cur_reg.center] = 1'b1;
                            slot_we           = 1'b1;
                            if (rec.count[SLOT_W-1:0] == '0)
                            begin
                                taken_next     = taken_reg + 1'b1;
                                ctr_wdata.tail = {1'b0, np};
                                slot_waddr     = {np, {SLOT_W{1'b0}}};
                                if (rec.count == '0)
                                    ctr_wdata.first = {1'b0, np};
                                else
                                begin
                                    link_we    = 1'b1;
                                    link_waddr = rec.tail[PAGE_W-1:0];
                                end
                            end
                            else
                                slot_waddr = {rec.tail[PAGE_W-1:0],
                                              rec.count[SLOT_W-1:0]};
                        end
                    end
                    else if (cur_reg.cmd == CMD_QUERY)
                        emit_val.entry_count = rec.count;
                end
            end
            BK_WREAD:
            begin
                slot_re    = 1'b1;
                state_next = BK_WEMIT;
            end
            BK_WEMIT:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_val.pair        = slot_rd_reg;
                    emit_val.has_pair    = 1'b1;
                    emit_val.entry_count = n_reg;
                    emit_val.last        = (idx_reg + 1'b1 == n_reg);
                    idx_next             = idx_reg + 1'b1;
                    if (slot_reg == SLOT_W'(SLOTS_PER_PAGE - 1))
                    begin
                        wpage_next = link_rd_reg[PAGE_W-1:0];
                        slot_next  = '0;
                    end
                    else
                        slot_next = slot_reg + 1'b1;
                    state_next = emit_val.last ? BK_IDLE : BK_WREAD;
                end
            end
            default: state_next = BK_IDLE;
        endcase

        out_next       = emit ? emit_val : out_reg;
        out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);
    end

endmodule

FILE: hdl/pnl_checker.sv
module pnl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] pair_out,
    input logic        has_pair,
    input logic [6:0]  entry_count,
    input logic        last,
    input logic [2:0]  status
);
    import pnl_pkg::*;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !has_pair && entry_count == '0)
        else $error("error result not single");

    a_no_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_pair |-> pair_out == '0 && last)
        else $error("result without pair malformed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 7'(MAX_PER_CENTER))
        else $error("entry count out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pair_out)
            && $stable(entry_count) && $stable(last) && $stable(status))
        else $error("stalled result changed");

endmodule

bind paged_neighbor_list pnl_checker u_pnl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pair_out    (pair_out),
    .has_pair    (has_pair),
    .entry_count (entry_count),
    .last        (last),
    .status      (status)
);
